@@ design/gpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// gpsd_pkg
// Shared constants and types for the pulse shape discriminator.
// ----------------------------------------------------------------------------
package gpsd_pkg;

  localparam int MAX_BINS  = 64;
  localparam int MAX_HITS  = 4095;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int EDGE_AW   = $clog2(MAX_BINS + 1);
  localparam int SLOT_W    = 7;
  localparam int NB_W      = 7;
  localparam int CNT_W     = 12;
  localparam int TIME_W    = 20;
  localparam int WGT_W     = 16;
  localparam int CFG_W     = 20;
  localparam int ACC_W     = 48;

  typedef enum logic [2:0] {
    OP_EDGE  = 3'd0,
    OP_PLAIN = 3'd1,
    OP_CUM   = 3'd2,
    OP_HIT   = 3'd3,
    OP_END   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REG_NBINS = 2'd0,
    REG_MINH  = 2'd1,
    REG_TAIL  = 2'd2,
    REG_ZWIN  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_BINRD, ST_BINWR, ST_SUMRD, ST_SUMACC, ST_DIVP,
    ST_DIVC, ST_DIVT, ST_CLR, ST_OUT, ST_INIT
  } state_t;

endpackage

@@ design/gpsd_div.sv @@
// ----------------------------------------------------------------------------
// gpsd_div
// Restoring divider, one quotient bit per cycle, unsigned 48 by 12.
// ----------------------------------------------------------------------------
module gpsd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gpsd_pkg::ACC_W-1:0] num,
  input  logic [gpsd_pkg::CNT_W-1:0] den,
  output logic                       done,
  output logic [gpsd_pkg::ACC_W-1:0] quo
);
  import gpsd_pkg::*;

  logic [ACC_W-1:0] q_r, q_nxt;
  logic [CNT_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] den_r, den_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W+1:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = '0;
    if (start) begin
      q_nxt = num; rem_nxt = '0; den_nxt = den;
      cnt_nxt = 6'(ACC_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[ACC_W-1]};
      q_nxt = {q_r[ACC_W-2:0], 1'b0};
      if (trial >= {2'b00, den_r}) begin
        rem_nxt = (CNT_W+1)'(trial - {2'b00, den_r});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[CNT_W:0];
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r;
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("div done while busy");

  property p_busy_count;
    @(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != 6'd0;
  endproperty
  a_busy_count: assert property (p_busy_count) else $error("div count underflow");

  property p_start_busy;
    @(posedge clk) disable iff (!rst_n) start |=> busy_r;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("div did not start");

endmodule

@@ design/gatti_pulse_shape_discriminator_top.sv @@
// ----------------------------------------------------------------------------
// gatti_pulse_shape_discriminator_top
// Histograms hit times per event, gives weighted sums and tail fraction.
// ----------------------------------------------------------------------------
// hit: range check on edge 0 and edge n, then bisection for an in-range hit,
//   one edge read per step, then read-modify-write of the bin count; one item
//   in flight at a time
// end of event: a sweep of all 64 count entries, then three bit-serial
//   divisions, then the result goes to the output stage
// reset: registers to reset values, then a pass over all 64 entries clears the counts
module gatti_pulse_shape_discriminator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_opcode,
  input  logic [gpsd_pkg::SLOT_W-1:0]   in_slot,
  input  logic signed [gpsd_pkg::TIME_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_event_valid,
  output logic signed [15:0]            out_weighted_plain,
  output logic signed [15:0]            out_weighted_cumulative,
  output logic [15:0]                   out_tail_fraction,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [gpsd_pkg::CFG_W-1:0]    cfg_data
);
  import gpsd_pkg::*;

  // memories
  logic signed [TIME_W-1:0] edge_mem [MAX_BINS+1];
  logic signed [WGT_W-1:0]  pw_mem   [MAX_BINS];
  logic signed [WGT_W-1:0]  cw_mem   [MAX_BINS];
  logic [CNT_W-1:0]         cnt_mem  [MAX_BINS];

  logic [NB_W-1:0]          nbins_r;
  logic [CNT_W-1:0]         minh_r;
  logic signed [TIME_W-1:0] tail_r;
  logic [9:0]               zwin_r;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]         hits_r, hits_nxt, tails_r, tails_nxt;
  logic signed [TIME_W-1:0] offs_r, offs_nxt;
  logic                     first_r, first_nxt;
  logic signed [TIME_W:0]   t_r, t_nxt;
  logic [EDGE_AW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [1:0]               chk_r, chk_nxt;
  logic                     inr_r, inr_nxt;
  logic [NB_W:0]            idx_r, idx_nxt;
  logic                     rdv_r, rdv_nxt;
  logic [BIN_W-1:0]         rdi_r, rdi_nxt;
  logic [CNT_W-1:0]         tot_r, tot_nxt, pre_r, pre_nxt;
  logic signed [ACC_W-1:0]  sp_r, sp_nxt, sc_r, sc_nxt;
  logic                     ov_r, ov_nxt;
  logic signed [15:0]       wp_r, wp_nxt, wc_r, wc_nxt;
  logic [15:0]              tf_r, tf_nxt;
  logic                     oval_r, oval_nxt;

  // output stage, frees the core while a result waits
  logic                     out_load;
  logic                     oev_r;
  logic signed [15:0]       owp_r, owc_r;
  logic [15:0]              otf_r;

  // memory ports
  logic [EDGE_AW-1:0]       e_ra;
  logic signed [TIME_W-1:0] e_rd;
  logic [BIN_W-1:0]         c_ra, c_wa;
  logic                     c_we;
  logic [CNT_W-1:0]         c_wd, c_rd;
  logic signed [WGT_W-1:0]  pw_rd, cw_rd;

  logic                     div_start, div_done;
  logic [ACC_W-1:0]         div_num, div_quo;
  logic [CNT_W-1:0]         div_den;

  logic [NB_W-1:0] n_use;
  logic            acc_in;
  logic signed [WGT_W-1:0] wsat;
  logic signed [TIME_W:0]  tv;
  logic [EDGE_AW-1:0] mid;
  logic signed [ACC_W-1:0] qs;
  logic [ACC_W-1:0] mag;
  logic signed [WGT_W+CNT_W:0] prod_p, prod_c;

  assign n_use  = (nbins_r == '0) ? NB_W'(1) :
                  (nbins_r > NB_W'(MAX_BINS)) ? NB_W'(MAX_BINS) : nbins_r;
  assign in_stall = (state_r != ST_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign out_load = (state_r == ST_OUT) && (!oval_r || !out_stall);
  assign wsat = in_value > 20'sd32767 ? 16'sh7fff :
                in_value < -20'sd32768 ? -16'sh8000 : in_value[WGT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbins_r <= NB_W'(59); minh_r <= CNT_W'(20); tail_r <= '0; zwin_r <= 10'd1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NBINS: nbins_r <= cfg_data[NB_W-1:0];
        REG_MINH:  minh_r  <= cfg_data[CNT_W-1:0];
        REG_TAIL:  tail_r  <= cfg_data;
        REG_ZWIN:  zwin_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (acc_in && opcode_t'(in_opcode) == OP_EDGE && in_slot <= SLOT_W'(MAX_BINS))
      edge_mem[in_slot[EDGE_AW-1:0]] <= in_value;
    if (acc_in && opcode_t'(in_opcode) == OP_PLAIN && in_slot < SLOT_W'(MAX_BINS))
      pw_mem[in_slot[BIN_W-1:0]] <= wsat;
    if (acc_in && opcode_t'(in_opcode) == OP_CUM && in_slot < SLOT_W'(MAX_BINS))
      cw_mem[in_slot[BIN_W-1:0]] <= wsat;
    if (c_we) cnt_mem[c_wa] <= c_wd;
    e_rd  <= edge_mem[e_ra];
    c_rd  <= cnt_mem[c_ra];
    pw_rd <= pw_mem[c_ra];
    cw_rd <= cw_mem[c_ra];
  end

  gpsd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_in && opcode_t'(in_opcode) == OP_HIT && hits_r < CNT_W'(MAX_HITS))
          state_nxt = ST_SRCH;
        else if (acc_in && opcode_t'(in_opcode) == OP_END)
          state_nxt = ST_SUMRD;
      end
      ST_SRCH:   if (chk_r == 2'd3 && (!inr_r || hi_r - lo_r <= EDGE_AW'(1)))
                   state_nxt = inr_r ? ST_BINRD : ST_IDLE;
      ST_BINRD:  state_nxt = ST_BINWR;
      ST_BINWR:  state_nxt = ST_IDLE;
      ST_SUMRD:  state_nxt = (idx_r == (NB_W+1)'(MAX_BINS)) ? ST_SUMACC : ST_SUMRD;
      ST_SUMACC: state_nxt = ST_DIVP;
      ST_DIVP:   if (div_done) state_nxt = ST_DIVC;
      ST_DIVC:   if (div_done) state_nxt = ST_DIVT;
      ST_DIVT:   if (div_done) state_nxt = ST_CLR;
      ST_CLR:    state_nxt = ST_OUT;
      ST_OUT:    state_nxt = out_load ? ST_IDLE : ST_OUT;
      ST_INIT:   if (idx_r == (NB_W+1)'(MAX_BINS - 1)) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    hits_nxt = hits_r; tails_nxt = tails_r; offs_nxt = offs_r; first_nxt = first_r;
    t_nxt = t_r; lo_nxt = lo_r; hi_nxt = hi_r; chk_nxt = chk_r; inr_nxt = inr_r;
    idx_nxt = idx_r; rdv_nxt = 1'b0; rdi_nxt = rdi_r; tot_nxt = tot_r;
    pre_nxt = pre_r; sp_nxt = sp_r; sc_nxt = sc_r; ov_nxt = ov_r;
    wp_nxt = wp_r; wc_nxt = wc_r; tf_nxt = tf_r; oval_nxt = oval_r;
    e_ra = '0; c_ra = rdi_r; c_wa = rdi_r; c_we = 1'b0; c_wd = '0;
    div_start = 1'b0; div_num = '0; div_den = tot_r;
    tv = '0; mid = '0; qs = '0; mag = '0; prod_p = '0; prod_c = '0;
    if (oval_r && !out_stall) oval_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc_in && opcode_t'(in_opcode) == OP_HIT && hits_r < CNT_W'(MAX_HITS)) begin
          if (!first_r) begin
            first_nxt = 1'b1;
            if (in_value < -$signed({11'd0, zwin_r}) ||
                in_value > $signed({11'd0, zwin_r})) begin
              offs_nxt = in_value;
              tv = '0;
            end else begin
              offs_nxt = '0;
              tv = {in_value[TIME_W-1], in_value};
            end
          end else begin
            tv = $signed({in_value[TIME_W-1], in_value}) -
                 $signed({offs_r[TIME_W-1], offs_r});
          end
          t_nxt = tv;
          hits_nxt = hits_r + CNT_W'(1);
          if (tv > $signed({tail_r[TIME_W-1], tail_r})) tails_nxt = tails_r + CNT_W'(1);
          lo_nxt = '0; hi_nxt = EDGE_AW'(n_use);
          chk_nxt = 2'd0; inr_nxt = 1'b1;
          e_ra = '0;
        end else if (acc_in && opcode_t'(in_opcode) == OP_END) begin
          idx_nxt = '0; tot_nxt = '0; pre_nxt = '0; sp_nxt = '0; sc_nxt = '0;
        end
      end
      // range check on edge 0 and edge n, then bisection
      ST_SRCH: begin
        case (chk_r)
          2'd0: begin e_ra = lo_r; chk_nxt = 2'd1; end
          2'd1: begin
            if (t_r < $signed({e_rd[TIME_W-1], e_rd})) inr_nxt = 1'b0;
            e_ra = hi_r; chk_nxt = 2'd2;
          end
          2'd2: begin
            if (t_r >= $signed({e_rd[TIME_W-1], e_rd})) inr_nxt = 1'b0;
            mid = EDGE_AW'((lo_r + hi_r) >> 1);
            e_ra = mid; chk_nxt = 2'd3;
          end
          default: begin
            mid = EDGE_AW'((lo_r + hi_r) >> 1);
            if (inr_r && hi_r - lo_r > EDGE_AW'(1)) begin
              if ($signed({e_rd[TIME_W-1], e_rd}) <= t_r) lo_nxt = mid;
              else hi_nxt = mid;
              e_ra = EDGE_AW'(((($signed({e_rd[TIME_W-1], e_rd}) <= t_r) ? mid : lo_r)
                     + (($signed({e_rd[TIME_W-1], e_rd}) <= t_r) ? hi_r : mid)) >> 1);
              chk_nxt = 2'd3;
            end
            rdi_nxt = lo_r[BIN_W-1:0];
          end
        endcase
        if (chk_r == 2'd2 && hi_r - lo_r <= EDGE_AW'(1)) chk_nxt = 2'd3;
      end
      ST_BINRD: c_ra = rdi_r;
      ST_BINWR: begin
        c_we = 1'b1; c_wd = c_rd + CNT_W'(1);
      end
      // sweep all count entries, sum the bins in use, clear each behind the read
      ST_SUMRD: begin
        if (idx_r != (NB_W+1)'(MAX_BINS)) begin
          c_ra = idx_r[BIN_W-1:0];
          rdi_nxt = idx_r[BIN_W-1:0];
          rdv_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (rdv_r) begin
          c_we = 1'b1; c_wa = rdi_r; c_wd = '0;
          if (NB_W'(rdi_r) < n_use) begin
            tot_nxt = tot_r + c_rd;
            pre_nxt = pre_r + c_rd;
            prod_p = pw_rd * $signed({1'b0, c_rd});
            prod_c = cw_rd * $signed({1'b0, pre_r + c_rd});
            sp_nxt = sp_r + ACC_W'(prod_p);
            sc_nxt = sc_r + ACC_W'(prod_c);
          end
        end
      end
      ST_SUMACC: begin
        ov_nxt = (hits_r >= minh_r) && (tot_r != '0);
        mag = sp_r[ACC_W-1] ? ACC_W'(-sp_r) : ACC_W'(sp_r);
        div_num = mag + ACC_W'(tot_r >> 1);
        div_start = 1'b1;
      end
      ST_DIVP: if (div_done) begin
        qs = sp_r[ACC_W-1] ? -$signed(div_quo) : $signed(div_quo);
        wp_nxt = qs > 48'sd32767 ? 16'sh7fff : qs < -48'sd32768 ? -16'sh8000 : qs[15:0];
        mag = sc_r[ACC_W-1] ? ACC_W'(-sc_r) : ACC_W'(sc_r);
        div_num = mag + ACC_W'(tot_r >> 1);
        div_start = 1'b1;
      end
      ST_DIVC: if (div_done) begin
        qs = sc_r[ACC_W-1] ? -$signed(div_quo) : $signed(div_quo);
        wc_nxt = qs > 48'sd32767 ? 16'sh7fff : qs < -48'sd32768 ? -16'sh8000 : qs[15:0];
        div_num = ACC_W'({tails_r, 16'd0});
        div_den = (hits_r == '0) ? CNT_W'(1) : hits_r;
        div_start = 1'b1;
      end
      ST_DIVT: if (div_done) begin
        tf_nxt = (div_quo > ACC_W'(65535)) ? 16'hffff : div_quo[15:0];
      end
      ST_CLR: begin
        hits_nxt = '0; tails_nxt = '0; offs_nxt = '0; first_nxt = 1'b0;
      end
      ST_OUT: begin
        if (out_load) oval_nxt = 1'b1;
      end
      // zero the count memory after reset
      ST_INIT: begin
        c_we = 1'b1; c_wa = idx_r[BIN_W-1:0]; c_wd = '0;
        idx_nxt = idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; chk_r <= chk_nxt; inr_r <= inr_nxt;
    rdi_r <= rdi_nxt; tot_r <= tot_nxt; pre_r <= pre_nxt;
    sp_r <= sp_nxt; sc_r <= sc_nxt; ov_r <= ov_nxt;
    wp_r <= wp_nxt; wc_r <= wc_nxt; tf_r <= tf_nxt;
    if (out_load) begin
      oev_r <= ov_r;
      owp_r <= ov_r ? wp_r : '0;
      owc_r <= ov_r ? wc_r : '0;
      otf_r <= ov_r ? tf_r : '0;
    end
    if (!rst_n) begin
      state_r <= ST_INIT; hits_r <= '0; tails_r <= '0; offs_r <= '0;
      first_r <= 1'b0; oval_r <= 1'b0; rdv_r <= 1'b0; idx_r <= '0;
    end else begin
      state_r <= state_nxt; hits_r <= hits_nxt; tails_r <= tails_nxt;
      offs_r <= offs_nxt; first_r <= first_nxt; oval_r <= oval_nxt; rdv_r <= rdv_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign out_valid = oval_r;
  assign out_event_valid = oev_r;
  assign out_weighted_plain = owp_r;
  assign out_weighted_cumulative = owc_r;
  assign out_tail_fraction = otf_r;

  property p_tail_le_hits;
    @(posedge clk) disable iff (!rst_n) tails_r <= hits_r;
  endproperty
  a_tail_le_hits: assert property (p_tail_le_hits) else $error("tail count above hits");

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) state_r != ST_IDLE |-> in_stall;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  property p_clear_after_out;
    @(posedge clk) disable iff (!rst_n) state_r == ST_OUT |-> hits_r == '0 && !first_r;
  endproperty
  a_clear_after_out: assert property (p_clear_after_out) else $error("event not cleared");

endmodule

@@ verif/gatti_pulse_shape_discriminator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gatti_pulse_shape_discriminator_top_tb
// Loads edge and weight tables, drives events of hit beats and checks each
// end-of-event result against a local model of the histogram, weighted sums
// and tail fraction, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module gatti_pulse_shape_discriminator_top_tb;
  import gpsd_pkg::*;

  typedef struct {
    logic               ev;
    logic signed [15:0] plain;
    logic signed [15:0] cumul;
    logic [15:0]        tfrac;
  } pulse_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_opcode = 3'd0;
  logic [SLOT_W-1:0]        in_slot = '0;
  logic signed [TIME_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_event_valid;
  logic signed [15:0]       out_weighted_plain;
  logic signed [15:0]       out_weighted_cumulative;
  logic [15:0]              out_tail_fraction;
  logic                     cfg_we = 1'b0;
  logic [1:0]               cfg_index = 2'd0;
  logic [CFG_W-1:0]         cfg_data = '0;

  gatti_pulse_shape_discriminator_top dut (.*);

  // model state
  longint edge_tab[MAX_BINS+1];
  longint plain_tab[MAX_BINS];
  longint cumul_tab[MAX_BINS];
  int     bin_cnt[MAX_BINS];
  int     hits_seen, tail_seen;
  longint t_offset;
  bit     first_hit_seen;
  int     nbins_reg = 59, minhits_reg = 20, zwin_reg = 1;
  longint tailcut_reg = 0;

  pulse_result_t expected_results[$];
  int errors = 0;
  int sent = 0;
  int snd_idle_pct = 0, rcv_stall_pct = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("gatti_pulse_shape_discriminator_top: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  function automatic longint sat_q412(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic int bins_used();
    if (nbins_reg < 1) return 1;
    if (nbins_reg > MAX_BINS) return MAX_BINS;
    return nbins_reg;
  endfunction

  function automatic void clear_histogram();
    foreach (bin_cnt[i]) bin_cnt[i] = 0;
    hits_seen = 0;
    tail_seen = 0;
    t_offset = 0;
    first_hit_seen = 0;
  endfunction

  function automatic void predict_beat(logic [2:0] op, logic [6:0] sl,
                                       logic signed [19:0] val);
    longint v, t, sp, sc, tot, pre, frac;
    int n, b;
    pulse_result_t r;
    v = longint'(val);
    n = bins_used();
    case (op)
      OP_EDGE: if (sl <= MAX_BINS) edge_tab[sl] = v;
      OP_PLAIN: if (sl < MAX_BINS) plain_tab[sl] = sat_q412(v);
      OP_CUM: if (sl < MAX_BINS) cumul_tab[sl] = sat_q412(v);
      OP_HIT: begin
        if (hits_seen < MAX_HITS) begin
          if (!first_hit_seen) begin
            first_hit_seen = 1;
            t_offset = (v < -zwin_reg || v > zwin_reg) ? v : 0;
          end
          t = v - t_offset;
          hits_seen++;
          if (t > tailcut_reg) tail_seen++;
          if (t >= edge_tab[0] && t < edge_tab[n]) begin
            b = 0;
            for (int k = 1; k < n; k++) if (edge_tab[k] <= t) b++;
            bin_cnt[b]++;
          end
        end
      end
      OP_END: begin
        tot = 0; pre = 0; sp = 0; sc = 0;
        for (int i = 0; i < n; i++) begin
          tot += bin_cnt[i];
          pre += bin_cnt[i];
          sp += plain_tab[i] * bin_cnt[i];
          sc += cumul_tab[i] * pre;
        end
        if (hits_seen >= minhits_reg && tot > 0) begin
          frac = (longint'(tail_seen) << 16) / hits_seen;
          r.ev = 1'b1;
          r.plain = 16'(sat_q412(round_div(sp, tot)));
          r.cumul = 16'(sat_q412(round_div(sc, tot)));
          r.tfrac = (frac > 65535) ? 16'hFFFF : 16'(frac);
        end else begin
          r = '{1'b0, 16'sd0, 16'sd0, 16'd0};
        end
        expected_results.insert(expected_results.size(), r);
        clear_histogram();
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    pulse_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with none expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_event_valid !== e.ev) begin
          $error("event_valid exp %0d got %0d", e.ev, out_event_valid);
          errors++;
        end
        if (out_weighted_plain !== e.plain) begin
          $error("weighted_plain exp %0d got %0d", e.plain, out_weighted_plain);
          errors++;
        end
        if (out_weighted_cumulative !== e.cumul) begin
          $error("weighted_cumulative exp %0d got %0d", e.cumul,
                 out_weighted_cumulative);
          errors++;
        end
        if (out_tail_fraction !== e.tfrac) begin
          $error("tail_fraction exp %0d got %0d", e.tfrac, out_tail_fraction);
          errors++;
        end
      end
    end
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_beat(logic [2:0] op, logic [6:0] sl, logic signed [19:0] val);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_slot   <= sl;
    in_value  <= val;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    predict_beat(op, sl, val);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // hits give no result, let the last one settle
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NBINS: nbins_reg = d[6:0];
      REG_MINH:  minhits_reg = d[11:0];
      REG_TAIL:  tailcut_reg = longint'($signed(d[19:0]));
      REG_ZWIN:  zwin_reg = d[9:0];
      default: ;
    endcase
  endtask

  task automatic send_hit(logic signed [19:0] v);
    send_beat(OP_HIT, 7'd0, v);
  endtask

  task automatic test_table_load();
    for (int k = 0; k <= MAX_BINS; k++) send_beat(OP_EDGE, 7'(k), 20'(-256 + 32 * k));
    for (int k = 0; k < MAX_BINS; k++) begin
      send_beat(OP_PLAIN, 7'(k), 20'($urandom_range(0, 16383) - 8192));
      send_beat(OP_CUM, 7'(k), 20'($urandom_range(0, 16383) - 8192));
    end
  endtask

  task automatic test_directed();
    write_reg(REG_MINH, 20'd0);
    write_reg(REG_NBINS, 20'd64);
    // empty event
    send_beat(OP_END, 7'd0, 20'sd0);
    // ignored slots and unused opcodes
    send_beat(OP_EDGE, 7'd65, 20'sd5);
    send_beat(OP_PLAIN, 7'd64, 20'sd7);
    send_beat(OP_CUM, 7'd127, 20'sd7);
    send_beat(3'd5, 7'h55, 20'h55555);
    send_beat(3'd6, 7'h2A, 20'hAAAAA);
    send_beat(3'd7, 7'h7F, 20'hFFFFF);
    // weights saturate beyond q4.12
    send_beat(OP_PLAIN, 7'd3, 20'sd524287);
    send_beat(OP_CUM, 7'd3, -20'sd524288);
    // first hit at the extremes, offset removes it
    send_hit(20'sd524287);
    send_beat(OP_END, 7'd0, 20'sd0);
    send_hit(-20'sd524288);
    send_beat(OP_END, 7'd0, 20'sd0);
    // first hit inside window, third out of range
    send_hit(20'sd1);
    send_hit(20'sd40);
    send_hit(20'sd5000);
    send_beat(OP_END, 7'd0, 20'sd0);
    // all hits in tail, fraction saturates
    write_reg(REG_TAIL, 20'h80000);
    write_reg(REG_ZWIN, 20'd1023);
    send_hit(20'sd0);
    send_hit(20'sd1023);
    send_hit(-20'sd200);
    send_beat(OP_END, 7'd0, 20'sd0);
    // only out-of-range hits
    write_reg(REG_NBINS, 20'd0);
    send_hit(-20'sd1000);
    send_hit(20'sd900);
    send_beat(OP_END, 7'd0, 20'sd0);
    write_reg(REG_NBINS, 20'd127);
    write_reg(REG_ZWIN, 20'd0);
    write_reg(REG_TAIL, 20'h7FFFF);
  endtask

  task automatic rand_event();
    int nh, k, zw;
    longint lo, hi, off, v;
    if ($urandom_range(0, 9) == 0)
      send_beat(3'($urandom_range(5, 7)), 7'($urandom), 20'($urandom));
    if ($urandom_range(0, 9) == 0)
      send_beat(3'($urandom_range(0, 2)), 7'($urandom_range(65, 127)), 20'($urandom));
    if ($urandom_range(0, 5) == 0)
      send_beat(3'($urandom_range(1, 2)), 7'($urandom_range(0, 63)), 20'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(1, 63);
      lo = edge_tab[k-1] + 1;
      hi = edge_tab[k+1] - 1;
      if (hi >= lo) send_beat(OP_EDGE, 7'(k), 20'(lo + $urandom_range(0, int'(hi - lo))));
    end
    nh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 40);
    zw = zwin_reg;
    off = 0;
    for (int i = 0; i < nh; i++) begin
      if (i == 0) begin
        if ($urandom_range(0, 1)) v = longint'($urandom_range(0, 2 * zw)) - zw;
        else begin
          off = longint'($urandom_range(0, 400000)) - 200000;
          v = off;
        end
        if (v < -zw || v > zw) off = v;
      end else begin
        v = off + longint'($urandom_range(0, 2600)) - 500;
      end
      send_hit(20'(v));
    end
    send_beat(OP_END, 7'd0, 20'sd0);
  endtask

  task automatic test_random(int n_items);
    int stop;
    stop = sent + n_items;
    while (sent < stop) begin
      rand_event();
      if ($urandom_range(0, 29) == 0) drain();
    end
  endtask

  task automatic set_random_config();
    write_reg(REG_NBINS, CFG_W'($urandom_range(0, 127)));
    write_reg(REG_MINH, CFG_W'($urandom_range(0, 30)));
    write_reg(REG_TAIL, CFG_W'($urandom_range(0, 2400) - 400));
    write_reg(REG_ZWIN, CFG_W'($urandom_range(0, 1023)));
  endtask

  initial begin
    clear_histogram();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_directed();
    snd_idle_pct = 8;
    rcv_stall_pct = 53;
    set_random_config();
    test_random(360);
    snd_idle_pct = 53;
    rcv_stall_pct = 8;
    write_reg(REG_NBINS, 20'd1);
    write_reg(REG_MINH, 20'd4095);
    write_reg(REG_MINH, 20'd3);
    test_random(360);
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    set_random_config();
    test_random(360);
    drain();
    if (errors == 0) begin
      $display("gatti_pulse_shape_discriminator_top: match");
    end else begin
      $display("gatti_pulse_shape_discriminator_top: mismatch");
    end
    $finish;
  end

endmodule

@@ gatti_pulse_shape_discriminator_top.f @@
design/gpsd_pkg.sv
design/gpsd_div.sv
design/gatti_pulse_shape_discriminator_top.sv
verif/gatti_pulse_shape_discriminator_top_tb.sv
